### src/cle_pkg.sv
// cle_pkg: shared widths, codes and controller/datapath command and status types
// for the cursor line editor. No dependencies.
package cle_pkg;

  localparam int unsigned LINE_MAX_DEF = 64;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned KEY_W        = 3;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 3;

  localparam logic [CHAR_W-1:0] CHAR_ENTER  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_LOW_LO = 8'h01;
  localparam logic [CHAR_W-1:0] CHAR_LOW_HI = 8'h10;
  localparam logic [CHAR_W-1:0] CHAR_PRINT  = 8'h20;

  localparam logic [KEY_W-1:0] KEY_BACK  = 3'd0;
  localparam logic [KEY_W-1:0] KEY_FWD   = 3'd1;
  localparam logic [KEY_W-1:0] KEY_START = 3'd2;
  localparam logic [KEY_W-1:0] KEY_END   = 3'd3;
  localparam logic [KEY_W-1:0] KEY_ERASE = 3'd4;

  localparam logic OP_CHAR = 1'b0;

  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  localparam logic ADDR_ENABLED = 1'b0;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic emit_next;
    logic emit_last;
  } stat_t;

endpackage

### src/cle_ctrl.sv
// cle_ctrl: controller state machine of the cursor line editor.
// Depends on cle_pkg for the command and status types.
module cle_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          take_i,
  input  cle_pkg::stat_t stat_i,
  output cle_pkg::cmd_t  cmd_o,
  output logic          busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (take_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= stat_i.emit_next ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (stat_i.emit_last) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.load = (state_q == ST_IDLE) && take_i;
    cmd_o.exec = (state_q == ST_EXEC);
    cmd_o.emit = (state_q == ST_EMIT);
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

### src/cle_datapath.sv
// cle_datapath: line store cells, length, cursor and result registers.
// Depends on cle_pkg; driven by cle_ctrl commands.
module cle_datapath #(
  parameter int unsigned LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cle_pkg::cmd_t              cmd_i,
  output cle_pkg::stat_t             stat_o,
  input  logic                       op_i,
  input  logic [cle_pkg::CHAR_W-1:0] char_code_i,
  input  logic [cle_pkg::KEY_W-1:0]  key_code_i,
  output logic                       result_valid_o,
  output logic [cle_pkg::KIND_W-1:0] kind_o,
  output logic [cle_pkg::CHAR_W-1:0] line_char_o,
  output logic                       last_o,
  output logic                       changed_o,
  output logic [cle_pkg::LEN_W-1:0]  length_o,
  output logic [cle_pkg::LEN_W-1:0]  cursor_o
);

  localparam int unsigned DEPTH = LINE_MAX - 1;
  localparam logic [cle_pkg::LEN_W-1:0] FULL_LEN = cle_pkg::LEN_W'(LINE_MAX - 1);

  logic                       op_q;
  logic [cle_pkg::CHAR_W-1:0] char_q;
  logic [cle_pkg::KEY_W-1:0]  key_q;
  logic [cle_pkg::LEN_W-1:0]  len_q, len_d;
  logic [cle_pkg::LEN_W-1:0]  cur_q, cur_d;
  logic [cle_pkg::LEN_W-1:0]  rem_q;
  logic [cle_pkg::CHAR_W-1:0] store_q [DEPTH];

  logic                       valid_q;
  logic [cle_pkg::KIND_W-1:0] kind_q;
  logic [cle_pkg::CHAR_W-1:0] lchar_q;
  logic                       last_q;
  logic                       changed_q;
  logic [cle_pkg::LEN_W-1:0]  olen_q;
  logic [cle_pkg::LEN_W-1:0]  ocur_q;

  logic                       is_enter;
  logic                       is_bs;
  logic                       is_ins;
  logic                       do_ins;
  logic                       do_rm;
  logic                       changed;
  logic [cle_pkg::LEN_W-1:0]  rm_pos;
  logic                       ins_en;
  logic                       rm_en;

  // item decode and edit result
  always_comb begin
    is_enter = (op_q == cle_pkg::OP_CHAR) && (char_q == cle_pkg::CHAR_ENTER);
    is_bs    = (op_q == cle_pkg::OP_CHAR) && (char_q == cle_pkg::CHAR_BSPACE);
    is_ins   = (op_q == cle_pkg::OP_CHAR) && !is_enter && !is_bs &&
               ((char_q >= cle_pkg::CHAR_PRINT) ||
                ((char_q >= cle_pkg::CHAR_LOW_LO) && (char_q <= cle_pkg::CHAR_LOW_HI)));
    do_ins   = 1'b0;
    do_rm    = 1'b0;
    changed  = 1'b0;
    rm_pos   = cur_q;
    len_d    = len_q;
    cur_d    = cur_q;
    if (is_enter) begin
      len_d   = '0;
      cur_d   = '0;
      changed = 1'b1;
    end else if (is_bs) begin
      if (cur_q != '0) begin
        do_rm   = 1'b1;
        rm_pos  = cur_q - 1'b1;
        len_d   = len_q - 1'b1;
        cur_d   = cur_q - 1'b1;
        changed = 1'b1;
      end
    end else if (is_ins) begin
      if (len_q < FULL_LEN) begin
        do_ins  = 1'b1;
        len_d   = len_q + 1'b1;
        cur_d   = cur_q + 1'b1;
        changed = 1'b1;
      end
    end else if (op_q != cle_pkg::OP_CHAR) begin
      case (key_q)
        cle_pkg::KEY_BACK: begin
          if (cur_q != '0) begin
            cur_d   = cur_q - 1'b1;
            changed = 1'b1;
          end
        end
        cle_pkg::KEY_FWD: begin
          if (cur_q < len_q) begin
            cur_d   = cur_q + 1'b1;
            changed = 1'b1;
          end
        end
        cle_pkg::KEY_START: begin
          cur_d   = '0;
          changed = 1'b1;
        end
        cle_pkg::KEY_END: begin
          cur_d   = len_q;
          changed = 1'b1;
        end
        cle_pkg::KEY_ERASE: begin
          if (cur_q < len_q) begin
            do_rm   = 1'b1;
            len_d   = len_q - 1'b1;
            changed = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign ins_en = cmd_i.exec && do_ins;
  assign rm_en  = (cmd_i.exec && do_rm) || cmd_i.emit;

  // one cell per character; each sees only its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [cle_pkg::CHAR_W-1:0] prev_c;
    logic [cle_pkg::CHAR_W-1:0] next_c;
    if (i == 0) begin : g_first
      assign prev_c = store_q[i];
    end else begin : g_mid
      assign prev_c = store_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_c = store_q[i];
    end else begin : g_body
      assign next_c = store_q[i+1];
    end
    always_ff @(posedge clk_i) begin
      if (ins_en) begin
        if (cle_pkg::LEN_W'(i) > cur_q) begin
          store_q[i] <= prev_c;
        end else if (cle_pkg::LEN_W'(i) == cur_q) begin
          store_q[i] <= char_q;
        end
      end else if (rm_en) begin
        if (cmd_i.emit || (cle_pkg::LEN_W'(i) >= rm_pos)) store_q[i] <= next_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      char_q <= char_code_i;
      key_q  <= key_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      cur_q   <= '0;
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cmd_i.exec) begin
        len_q   <= len_d;
        cur_q   <= cur_d;
        rem_q   <= len_q;
        valid_q <= !(is_enter && (len_q != '0));
      end else if (cmd_i.emit) begin
        rem_q   <= rem_q - 1'b1;
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      kind_q    <= is_enter ? cle_pkg::KIND_EMPTY : cle_pkg::KIND_STATUS;
      lchar_q   <= '0;
      last_q    <= 1'b1;
      changed_q <= changed;
      olen_q    <= len_d;
      ocur_q    <= cur_d;
    end else if (cmd_i.emit) begin
      kind_q    <= cle_pkg::KIND_CHAR;
      lchar_q   <= store_q[0];
      last_q    <= (rem_q == cle_pkg::LEN_W'(1));
      changed_q <= 1'b1;
      olen_q    <= '0;
      ocur_q    <= '0;
    end
  end

  assign stat_o.emit_next = is_enter && (len_q != '0);
  assign stat_o.emit_last = (rem_q == cle_pkg::LEN_W'(1));

  assign result_valid_o = valid_q;
  assign kind_o         = kind_q;
  assign line_char_o    = lchar_q;
  assign last_o         = last_q;
  assign changed_o      = changed_q;
  assign length_o       = olen_q;
  assign cursor_o       = ocur_q;

endmodule

### src/cursor_line_editor.sv
// cursor_line_editor: top level with the register port, controller and datapath.
// Depends on cle_pkg, cle_ctrl and cle_datapath.
// a status result is registered after its beat is loaded and run in the exec state; busy is high
// while the beat runs, so no new item is taken until it is done. enter on n characters gives n
// results on consecutive cycles, from the emit state, and holds busy through the exec and emit states.
// reset clears length, cursor and the strobe and sets enabled; results cannot be stalled.
module cursor_line_editor #(
  parameter int unsigned LINE_MAX = cle_pkg::LINE_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cle_pkg::ADDR_W-1:0]  paddr,
  input  logic [cle_pkg::DATA_W-1:0]  pwdata,
  output logic [cle_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op_i,
  input  logic [cle_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [cle_pkg::KEY_W-1:0]   key_code_i,
  output logic                        result_valid_o,
  output logic [cle_pkg::KIND_W-1:0]  kind_o,
  output logic [cle_pkg::CHAR_W-1:0]  line_char_o,
  output logic                        last_o,
  output logic                        changed_o,
  output logic [cle_pkg::LEN_W-1:0]   length_o,
  output logic [cle_pkg::LEN_W-1:0]   cursor_o
);

  logic           enabled_q;
  logic           take;
  cle_pkg::cmd_t  cmd;
  cle_pkg::stat_t stat;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[cle_pkg::ADDR_W-1] == cle_pkg::ADDR_ENABLED)) begin
      enabled_q <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[cle_pkg::ADDR_W-1])
      cle_pkg::ADDR_ENABLED: prdata[0] = enabled_q;
      default:               prdata    = '0;
    endcase
  end

  // a beat offered while disabled is not taken and gives no result
  assign take = start && !busy && enabled_q;

  cle_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  cle_datapath #(
    .LINE_MAX (LINE_MAX)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .char_code_i    (char_code_i),
    .key_code_i     (key_code_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .line_char_o    (line_char_o),
    .last_o         (last_o),
    .changed_o      (changed_o),
    .length_o       (length_o),
    .cursor_o       (cursor_o)
  );

endmodule

### dv/tb_cursor_line_editor.sv
// tb_cursor_line_editor: self-checking testbench for the cursor line editor,
// directed keystroke table, full-line fill and random typing against a line predictor.
// Depends on cle_pkg and cursor_line_editor.
`timescale 1ns / 1ps

module tb_cursor_line_editor;

  localparam int LINE_LIMIT = cle_pkg::LINE_MAX_DEF - 1;
  localparam logic OP_KEY = ~cle_pkg::OP_CHAR;
  localparam logic [cle_pkg::ADDR_W-1:0] ENABLED_ADDR =
    cle_pkg::ADDR_W'(4 * int'(cle_pkg::ADDR_ENABLED));

  typedef struct packed {
    logic [cle_pkg::KIND_W-1:0] kind;
    logic [cle_pkg::CHAR_W-1:0] ch;
    logic                       is_last;
    logic                       changed;
    logic [cle_pkg::LEN_W-1:0]  len;
    logic [cle_pkg::LEN_W-1:0]  cur;
  } editor_beat_t;

  typedef struct {
    logic                       op;
    logic [cle_pkg::CHAR_W-1:0] ch;
    logic [cle_pkg::KEY_W-1:0]  key;
    bit                         typed;
    editor_beat_t               beat;
  } keystroke_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [cle_pkg::ADDR_W-1:0]   paddr;
  logic [cle_pkg::DATA_W-1:0]   pwdata;
  logic [cle_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         start;
  logic                         busy;
  logic                         op_i;
  logic [cle_pkg::CHAR_W-1:0]   char_code_i;
  logic [cle_pkg::KEY_W-1:0]    key_code_i;
  logic                         result_valid_o;
  logic [cle_pkg::KIND_W-1:0]   kind_o;
  logic [cle_pkg::CHAR_W-1:0]   line_char_o;
  logic                         last_o;
  logic                         changed_o;
  logic [cle_pkg::LEN_W-1:0]    length_o;
  logic [cle_pkg::LEN_W-1:0]    cursor_o;

  cursor_line_editor dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .char_code_i    (char_code_i),
    .key_code_i     (key_code_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .line_char_o    (line_char_o),
    .last_o         (last_o),
    .changed_o      (changed_o),
    .length_o       (length_o),
    .cursor_o       (cursor_o)
  );

  // predicted editor state
  logic [cle_pkg::CHAR_W-1:0] ed_line [cle_pkg::LINE_MAX_DEF];
  int                         ed_len;
  int                         ed_cur;
  logic                       ed_enabled;

  editor_beat_t      step_beats[$];
  editor_beat_t      pending_beats[$];
  int                mismatches;
  int                burst_left;
  keystroke_row_t    directed_rows[25];

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic void drop_char(int pos);
    for (int i = pos; i + 1 < ed_len; i++) ed_line[i] = ed_line[i+1];
    ed_len--;
  endfunction

  task automatic apply_keystroke(input logic op, input logic [cle_pkg::CHAR_W-1:0] ch,
                                 input logic [cle_pkg::KEY_W-1:0] key);
    int   n;
    logic changed;
    step_beats.delete();
    changed = 1'b0;
    if (!ed_enabled) return;
    if (op == cle_pkg::OP_CHAR && ch == cle_pkg::CHAR_ENTER) begin
      n = ed_len;
      ed_len = 0;
      ed_cur = 0;
      if (n == 0) step_beats.push_back('{cle_pkg::KIND_EMPTY, '0, 1'b1, 1'b1, '0, '0});
      else
        for (int i = 0; i < n; i++)
          step_beats.push_back('{cle_pkg::KIND_CHAR, ed_line[i], 1'(i == n - 1), 1'b1,
                                 '0, '0});
      return;
    end
    if (op == cle_pkg::OP_CHAR) begin
      if (ch == cle_pkg::CHAR_BSPACE) begin
        if (ed_cur > 0) begin
          drop_char(ed_cur - 1);
          ed_cur--;
          changed = 1'b1;
        end
      end else if (ch >= cle_pkg::CHAR_PRINT ||
                   (ch >= cle_pkg::CHAR_LOW_LO && ch <= cle_pkg::CHAR_LOW_HI)) begin
        if (ed_len < LINE_LIMIT) begin
          for (int i = ed_len; i > ed_cur; i--) ed_line[i] = ed_line[i-1];
          ed_line[ed_cur] = ch;
          ed_len++;
          ed_cur++;
          changed = 1'b1;
        end
      end
    end else begin
      case (key)
        cle_pkg::KEY_BACK: begin
          if (ed_cur > 0) begin
            ed_cur--;
            changed = 1'b1;
          end
        end
        cle_pkg::KEY_FWD: begin
          if (ed_cur < ed_len) begin
            ed_cur++;
            changed = 1'b1;
          end
        end
        cle_pkg::KEY_START: begin
          ed_cur = 0;
          changed = 1'b1;
        end
        cle_pkg::KEY_END: begin
          ed_cur = ed_len;
          changed = 1'b1;
        end
        cle_pkg::KEY_ERASE: begin
          if (ed_cur < ed_len) begin
            drop_char(ed_cur);
            changed = 1'b1;
          end
        end
        default: ;
      endcase
    end
    step_beats.push_back('{cle_pkg::KIND_STATUS, '0, 1'b1, changed,
                           cle_pkg::LEN_W'(ed_len), cle_pkg::LEN_W'(ed_cur)});
  endtask

  task automatic send_keystroke(input logic op, input logic [cle_pkg::CHAR_W-1:0] ch,
                                input logic [cle_pkg::KEY_W-1:0] key, input bit typed,
                                input editor_beat_t typed_beat);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 17);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(4, 16);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    op_i = op;
    char_code_i = ch;
    key_code_i = key;
    do @(posedge clk_i); while (busy);
    apply_keystroke(op, ch, key);
    if (typed) pending_beats.push_back(typed_beat);
    else foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    @(negedge clk_i);
  endtask

  task automatic random_keystroke();
    int                         pick;
    logic                       op;
    logic [cle_pkg::CHAR_W-1:0] ch;
    logic [cle_pkg::KEY_W-1:0]  key;
    pick = $urandom_range(0, 99);
    op = cle_pkg::OP_CHAR;
    ch = cle_pkg::CHAR_W'($urandom_range(0, 255));
    key = cle_pkg::KEY_W'($urandom_range(0, 7));
    if (pick < 50) ch = cle_pkg::CHAR_W'($urandom_range(cle_pkg::CHAR_PRINT, 8'hFF));
    else if (pick < 60) ;
    else if (pick < 80) op = OP_KEY;
    else if (pick < 88) ch = cle_pkg::CHAR_BSPACE;
    else if (pick < 94) ch = cle_pkg::CHAR_ENTER;
    else op = 1'($urandom_range(0, 1));
    send_keystroke(op, ch, key, 1'b0, '0);
  endtask

  task automatic wait_line_idle();
    start = 1'b0;
    while (pending_beats.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_enabled(input logic val);
    logic [cle_pkg::DATA_W-1:0] rd;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ENABLED_ADDR;
    pwdata = cle_pkg::DATA_W'(val);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    ed_enabled = val;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    if (rd[0] !== val) begin
      $display("%0t enabled readback expected %0d actual %0d", $time, val, rd[0]);
      mismatches++;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    editor_beat_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat expected none actual kind %0d char %0d len %0d cur %0d",
                 $time, kind_o, line_char_o, length_o, cursor_o);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("kind", want.kind, kind_o);
        check_field("line_char", want.ch, line_char_o);
        check_field("last", want.is_last, last_o);
        check_field("changed", want.changed, changed_o);
        check_field("length", want.len, length_o);
        check_field("cursor", want.cur, cursor_o);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("FAIL cursor_line_editor");
    $finish;
  end

  initial begin
    directed_rows = '{
      '{OP_KEY, 8'h00, cle_pkg::KEY_BACK, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{OP_KEY, 8'h00, cle_pkg::KEY_FWD, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{cle_pkg::OP_CHAR, cle_pkg::CHAR_BSPACE, 3'd0, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{OP_KEY, 8'h00, cle_pkg::KEY_ERASE, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{cle_pkg::OP_CHAR, cle_pkg::CHAR_ENTER, 3'd0, 1'b1,
        '{cle_pkg::KIND_EMPTY, 8'h00, 1'b1, 1'b1, 6'd0, 6'd0}},
      '{cle_pkg::OP_CHAR, 8'h00, 3'd0, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{cle_pkg::OP_CHAR, 8'h11, 3'd0, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{cle_pkg::OP_CHAR, 8'h1F, 3'd7, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{OP_KEY, 8'hFF, 3'd5, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{OP_KEY, 8'h00, 3'd7, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b0, 6'd0, 6'd0}},
      '{cle_pkg::OP_CHAR, cle_pkg::CHAR_LOW_LO, 3'd0, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b1, 6'd1, 6'd1}},
      '{cle_pkg::OP_CHAR, cle_pkg::CHAR_LOW_HI, 3'd0, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b1, 6'd2, 6'd2}},
      '{cle_pkg::OP_CHAR, cle_pkg::CHAR_PRINT, 3'd0, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b1, 6'd3, 6'd3}},
      '{cle_pkg::OP_CHAR, 8'hFF, 3'd0, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b1, 6'd4, 6'd4}},
      '{OP_KEY, 8'h00, cle_pkg::KEY_START, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b1, 6'd4, 6'd0}},
      '{OP_KEY, 8'h00, cle_pkg::KEY_START, 1'b1,
        '{cle_pkg::KIND_STATUS, 8'h00, 1'b1, 1'b1, 6'd4, 6'd0}},
      '{cle_pkg::OP_CHAR, 8'h41, 3'd0, 1'b0, '0},
      '{OP_KEY, 8'h00, cle_pkg::KEY_END, 1'b0, '0},
      '{OP_KEY, 8'h00, cle_pkg::KEY_END, 1'b0, '0},
      '{OP_KEY, 8'h00, cle_pkg::KEY_BACK, 1'b0, '0},
      '{OP_KEY, 8'h00, cle_pkg::KEY_BACK, 1'b0, '0},
      '{OP_KEY, 8'h00, cle_pkg::KEY_ERASE, 1'b0, '0},
      '{cle_pkg::OP_CHAR, cle_pkg::CHAR_BSPACE, 3'd0, 1'b0, '0},
      '{OP_KEY, 8'h00, cle_pkg::KEY_FWD, 1'b0, '0},
      '{cle_pkg::OP_CHAR, cle_pkg::CHAR_ENTER, 3'd0, 1'b0, '0}
    };
    mismatches = 0;
    burst_left = 0;
    ed_len = 0;
    ed_cur = 0;
    ed_enabled = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    op_i = cle_pkg::OP_CHAR;
    char_code_i = '0;
    key_code_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    write_enabled(1'b1);

    foreach (directed_rows[i])
      send_keystroke(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].key,
                     directed_rows[i].typed, directed_rows[i].beat);

    // fill to the limit, then one more that must be dropped
    repeat (LINE_LIMIT + 1)
      send_keystroke(cle_pkg::OP_CHAR,
                     cle_pkg::CHAR_W'($urandom_range(cle_pkg::CHAR_PRINT, 8'hFF)),
                     '0, 1'b0, '0);
    send_keystroke(OP_KEY, '0, cle_pkg::KEY_START, 1'b0, '0);
    send_keystroke(OP_KEY, '0, cle_pkg::KEY_ERASE, 1'b0, '0);
    send_keystroke(OP_KEY, '0, cle_pkg::KEY_END, 1'b0, '0);
    send_keystroke(OP_KEY, '0, cle_pkg::KEY_ERASE, 1'b0, '0);
    send_keystroke(cle_pkg::OP_CHAR, 8'h7E, '0, 1'b0, '0);
    send_keystroke(cle_pkg::OP_CHAR, cle_pkg::CHAR_ENTER, '0, 1'b0, '0);

    for (int i = 0; i < 14; i++) begin
      if (i == 7) wait_line_idle();
      random_keystroke();
    end
    wait_line_idle();
    write_enabled(1'b0);
    repeat (4) random_keystroke();
    wait_line_idle();
    write_enabled(1'b1);
    repeat (12) random_keystroke();
    wait_line_idle();
    repeat (6) @(posedge clk_i);

    if (mismatches == 0 && pending_beats.size() == 0) $display("PASS cursor_line_editor");
    else $display("FAIL cursor_line_editor");
    $finish;
  end

endmodule
